[rtl/pces_pkg.sv]
// pces_pkg: shared types, constants and constant functions for the pendulum chain energy block
// used by pces_cos_rom, pces_prod_unit and pendulum_chain_energy_sum_top
// no dependencies
package pces_pkg;

    localparam int LIMB_W     = 32;
    localparam int LIMBS      = 7;
    localparam int LIMB_IDX_W = 3;
    localparam int BIG_W      = LIMB_W * LIMBS;
    localparam int FACTOR_W   = 34;
    localparam int CARRY_W    = 34;

    localparam int SHIFT_KIN  = 65;
    localparam int SHIFT_GRAV = 68;
    localparam int SHIFT_HARM = 111;
    localparam int SHIFT_CPL  = 127;

    localparam logic [FACTOR_W-1:0] INV_2PI_Q32 = 34'd683565276;
    localparam logic [51:0]         INV_2PI_WRAP = {INV_2PI_Q32[19:0], 32'b0};
    localparam logic [63:0]         HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
    localparam logic [32:0]         ONE_Q30 = 33'h0_4000_0000;

    localparam logic [1:0] MODE_GRAV  = 2'd0;
    localparam logic [1:0] MODE_HARM  = 2'd1;
    localparam logic [1:0] MODE_NONE  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [1:0] CFG_INV_DT   = 2'd0;
    localparam logic [1:0] CFG_POT_MODE = 2'd1;
    localparam logic [1:0] CFG_RING     = 2'd2;

    typedef struct packed {
        logic signed [31:0] angle_now;
        logic signed [31:0] angle_before;
        logic        [23:0] bob_mass;
        logic        [23:0] arm_length;
        logic signed [31:0] gravity_factor;
        logic signed [31:0] coupling_factor;
        logic signed [31:0] phase_offset;
        logic               last_item;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] kinetic_sum;
        logic signed [63:0] coupling_sum;
        logic signed [63:0] potential_sum;
        logic signed [63:0] total_sum;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic                load;
        logic                start;
        logic [FACTOR_W-1:0] factor;
    } prod_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } prod_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TURN_LOAD,
        ST_TURN_MUL,
        ST_TURN_WAIT,
        ST_INDEX,
        ST_SCALE,
        ST_ROM,
        ST_COS,
        ST_TERM_LOAD,
        ST_TERM_MUL,
        ST_TERM_WAIT,
        ST_EXTRACT,
        ST_ADD,
        ST_TOTAL,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        TERM_KIN,
        TERM_POT,
        TERM_CPL_HELD,
        TERM_CPL_RING
    } term_t;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] pr;
        pr = {64'b0, a} * {64'b0, b};
        return pr[125:62];
    endfunction

    // taylor series of cos in q62, rounded to q1.30
    function automatic logic [31:0] cos_q30(input logic [63:0] z, input logic neg);
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] p;
        logic [63:0] c;
        int          n;
        z2   = mul_q62(z, z);
        term = 64'h4000_0000_0000_0000;
        sum  = term;
        for (n = 1; n <= 11; n++)
        begin
            p = mul_q62(term, z2);
            case (n)
                1:       term = p / 64'd2;
                2:       term = p / 64'd12;
                3:       term = p / 64'd30;
                4:       term = p / 64'd56;
                5:       term = p / 64'd90;
                6:       term = p / 64'd132;
                7:       term = p / 64'd182;
                8:       term = p / 64'd240;
                9:       term = p / 64'd306;
                10:      term = p / 64'd380;
                default: term = p / 64'd462;
            endcase
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum[63])
            sum = 64'd0;
        c = (sum + 64'h8000_0000) >> 32;
        if (c > 64'h4000_0000)
            c = 64'h4000_0000;
        return neg ? 32'(64'd0 - c) : c[31:0];
    endfunction

endpackage

[rtl/pces_cos_rom.sv]
// pces_cos_rom: one-period cosine table in q1.30 with registered read
// depends on pces_pkg (cos_q30, HALF_PI_Q62)
module pces_cos_rom #(
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int IDX_W = 10
) (
    input  logic              clk,
    input  logic [IDX_W-1:0]  addr,
    output logic [31:0]       data
);

    localparam logic [63:0] Z_STEP = pces_pkg::HALF_PI_Q62 / 64'(COS_TABLE_DEPTH);
    localparam logic [63:0] Z_REM  = pces_pkg::HALF_PI_Q62 % 64'(COS_TABLE_DEPTH);

    logic [31:0] rom [COS_TABLE_DEPTH];
    logic [31:0] data_reg;

    for (genvar k = 0; k < COS_TABLE_DEPTH; k++)
    begin : g_entry
        // fold the angle into the first quadrant, sign from the second and third
        localparam logic [63:0] U0  = 64'(4 * k);
        localparam logic [63:0] U1  = (U0 > 64'(2 * COS_TABLE_DEPTH)) ?
                                      64'(4 * COS_TABLE_DEPTH) - U0 : U0;
        localparam bit          NEG = (U1 > 64'(COS_TABLE_DEPTH));
        localparam logic [63:0] U   = NEG ? 64'(2 * COS_TABLE_DEPTH) - U1 : U1;
        localparam logic [63:0] Z   = Z_STEP * U + (Z_REM * U) / COS_TABLE_DEPTH;
        assign rom[k] = pces_pkg::cos_q30(Z, NEG);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

[rtl/pces_prod_unit.sv]
// pces_prod_unit: wide product register multiplied by one factor, one 32-bit limb a cycle
// depends on pces_pkg (prod_ctl_t, prod_stat_t, limb constants)
module pces_prod_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pces_pkg::prod_ctl_t           ctl,
    output pces_pkg::prod_stat_t          stat,
    output logic [pces_pkg::BIG_W-1:0]    big
);

    localparam logic [pces_pkg::LIMB_IDX_W-1:0] LAST_LIMB =
        pces_pkg::LIMB_IDX_W'(pces_pkg::LIMBS - 1);

    logic [pces_pkg::LIMB_W-1:0]     limb_reg [pces_pkg::LIMBS];
    logic [pces_pkg::LIMB_IDX_W-1:0] idx_reg;
    logic [pces_pkg::LIMB_IDX_W-1:0] idx_next;
    logic                            busy_reg;
    logic                            busy_next;
    logic [pces_pkg::CARRY_W-1:0]    carry_reg;
    logic [pces_pkg::FACTOR_W-1:0]   factor_reg;
    logic [65:0]                     step;

    assign step = {34'b0, limb_reg[idx_reg]} * {32'b0, factor_reg} + {32'b0, carry_reg};

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg)
        begin
            if (idx_reg == LAST_LIMB)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            limb_reg[0] <= ctl.factor[31:0];
            limb_reg[1] <= {30'b0, ctl.factor[33:32]};
            for (int i = 2; i < pces_pkg::LIMBS; i++)
                limb_reg[i] <= '0;
        end
        else if (busy_reg)
        begin
            limb_reg[idx_reg] <= step[31:0];
        end
        if (ctl.start)
        begin
            factor_reg <= ctl.factor;
            carry_reg  <= '0;
        end
        else if (busy_reg)
        begin
            carry_reg <= step[65:32];
        end
    end

    for (genvar i = 0; i < pces_pkg::LIMBS; i++)
    begin : g_flat
        assign big[i*pces_pkg::LIMB_W +: pces_pkg::LIMB_W] = limb_reg[i];
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (idx_reg == LAST_LIMB);

endmodule

[rtl/pendulum_chain_energy_sum_top.sv]
// pendulum_chain_energy_sum_top: energy sums over a chain of pendulums, one item per transfer
// depends on pces_pkg, pces_prod_unit and pces_cos_rom
//
// The input is stalled while an item is being worked on. Every energy term is built as an
// exact product of five to seven factors in a 224-bit register by one shared 32x34 multiplier
// that steps through 7 limbs per factor; the cosine index needs one more such pass plus the
// index, scale, table read and cosine steps. Each item runs that pass, the kinetic energy
// term, the potential term when enabled and each coupling term, and the last item also forms
// the total; the emit step also waits while an earlier result is still stalled at the output.
// A finished result sits in the output register while the next item is already being taken.
module pendulum_chain_energy_sum_top #(
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pces_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pces_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int IDX_W   = $clog2(COS_TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(COS_TABLE_DEPTH + 1);
    localparam int SCALE_W = 32 + DEPTH_W + 1;

    pces_pkg::state_t     state_reg;
    pces_pkg::state_t     state_next;
    pces_pkg::term_t      term_reg;
    pces_pkg::term_t      term_next;
    logic [2:0]           fidx_reg;
    pces_pkg::prod_ctl_t  prod_ctl;
    pces_pkg::prod_stat_t prod_stat;
    logic [pces_pkg::BIG_W-1:0] big;

    logic [31:0] inv_dt_reg;
    logic [1:0]  mode_reg;
    logic        ring_reg;

    pces_pkg::in_item_t item_reg;
    logic signed [63:0] kin_acc_reg;
    logic signed [63:0] cpl_acc_reg;
    logic signed [63:0] pot_acc_reg;
    logic               ovf_reg;
    logic               have_held_reg;
    logic signed [31:0] held_angle_reg;
    logic        [23:0] held_mass_reg;
    logic        [23:0] held_length_reg;
    logic signed [31:0] held_coupling_reg;
    logic signed [31:0] held_phase_reg;
    logic signed [31:0] first_angle_reg;
    logic [31:0]        turns_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [31:0]        omc_reg;
    logic [63:0]        term_val_reg;
    logic               term_ovf_reg;
    logic signed [63:0] t1_reg;
    logic               out_valid_reg;
    pces_pkg::out_item_t out_reg;

    logic [31:0] cos_q;
    logic        in_accept;
    logic        emit_go;

    // ---------------------------------------------------------------- helpers

    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return {1'b1, a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
        return {1'b0, s};
    endfunction

    function automatic logic [32:0] mag32(input logic [31:0] x);
        logic [32:0] e;
        e = {x[31], x};
        return e[32] ? 33'd0 - e : e;
    endfunction

    // ---------------------------------------------------------------- operands

    logic [32:0] v_diff;
    logic [32:0] v_mag;
    logic [32:0] a_mag;
    logic [32:0] g_mag;
    logic        g_pos;
    logic signed [31:0] cx;
    logic signed [31:0] cn;
    logic signed [31:0] cp;
    logic        [23:0] cm;
    logic        [23:0] cl;
    logic signed [31:0] ck;
    logic [33:0] dm_diff;
    logic [33:0] dm_mag;
    logic [32:0] k_mag;
    logic        k_pos;

    assign v_diff = {item_reg.angle_now[31], item_reg.angle_now}
                  - {item_reg.angle_before[31], item_reg.angle_before};
    assign v_mag  = v_diff[32] ? 33'd0 - v_diff : v_diff;
    assign a_mag  = mag32(item_reg.angle_now);
    assign g_mag  = mag32(item_reg.gravity_factor);
    assign g_pos  = !item_reg.gravity_factor[31] && (item_reg.gravity_factor != 32'sd0);

    always_comb
    begin
        if (term_reg == pces_pkg::TERM_CPL_HELD)
        begin
            cx = held_angle_reg;
            cn = item_reg.angle_now;
            cp = held_phase_reg;
            cm = held_mass_reg;
            cl = held_length_reg;
            ck = held_coupling_reg;
        end
        else
        begin
            cx = item_reg.angle_now;
            cn = first_angle_reg;
            cp = item_reg.phase_offset;
            cm = item_reg.bob_mass;
            cl = item_reg.arm_length;
            ck = item_reg.coupling_factor;
        end
    end

    assign dm_diff = {{2{cx[31]}}, cx} - ({{2{cn[31]}}, cn} - {{2{cp[31]}}, cp});
    assign dm_mag  = dm_diff[33] ? 34'd0 - dm_diff : dm_diff;
    assign k_mag   = mag32(ck);
    assign k_pos   = !ck[31] && (ck != 32'sd0);

    logic        pot_grav;
    logic [33:0] factor;
    logic [2:0]  fcount;
    logic        term_neg;

    assign pot_grav = (mode_reg == pces_pkg::MODE_GRAV);

    always_comb
    begin
        factor   = {2'b0, inv_dt_reg};
        fcount   = 3'd7;
        term_neg = 1'b0;
        case (term_reg)
            pces_pkg::TERM_KIN:
            begin
                fcount = 3'd6;
                case (fidx_reg)
                    3'd0, 3'd1: factor = {1'b0, v_mag};
                    3'd2:       factor = {10'b0, item_reg.bob_mass};
                    3'd3, 3'd4: factor = {10'b0, item_reg.arm_length};
                    default:    factor = {2'b0, inv_dt_reg};
                endcase
            end
            pces_pkg::TERM_POT:
            begin
                fcount   = pot_grav ? 3'd5 : 3'd6;
                term_neg = g_pos;
                case (fidx_reg)
                    3'd0:    factor = {10'b0, item_reg.bob_mass};
                    3'd1:    factor = {1'b0, g_mag};
                    3'd2:    factor = {10'b0, item_reg.arm_length};
                    3'd3:    factor = pot_grav ? {2'b0, omc_reg} : {1'b0, a_mag};
                    3'd4:    factor = pot_grav ? {2'b0, inv_dt_reg} : {1'b0, a_mag};
                    default: factor = {2'b0, inv_dt_reg};
                endcase
            end
            default:
            begin
                fcount   = 3'd7;
                term_neg = k_pos;
                case (fidx_reg)
                    3'd0, 3'd1: factor = dm_mag;
                    3'd2, 3'd3: factor = {10'b0, cl};
                    3'd4:       factor = {10'b0, cm};
                    3'd5:       factor = {1'b0, k_mag};
                    default:    factor = {2'b0, inv_dt_reg};
                endcase
            end
        endcase
    end

    // ---------------------------------------------------------------- term extraction

    logic [63:0] ex_mag;
    logic        ex_high;
    logic [63:0] ex_limit;
    logic [63:0] ex_val;
    logic        ex_ovf;

    always_comb
    begin
        case (term_reg)
            pces_pkg::TERM_KIN:
            begin
                ex_mag  = big[pces_pkg::SHIFT_KIN +: 64];
                ex_high = |big[pces_pkg::BIG_W-1:pces_pkg::SHIFT_KIN+64];
            end
            pces_pkg::TERM_POT:
            begin
                if (pot_grav)
                begin
                    ex_mag  = big[pces_pkg::SHIFT_GRAV +: 64];
                    ex_high = |big[pces_pkg::BIG_W-1:pces_pkg::SHIFT_GRAV+64];
                end
                else
                begin
                    ex_mag  = big[pces_pkg::SHIFT_HARM +: 64];
                    ex_high = |big[pces_pkg::BIG_W-1:pces_pkg::SHIFT_HARM+64];
                end
            end
            default:
            begin
                ex_mag  = big[pces_pkg::SHIFT_CPL +: 64];
                ex_high = |big[pces_pkg::BIG_W-1:pces_pkg::SHIFT_CPL+64];
            end
        endcase
        ex_limit = term_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        ex_ovf   = ex_high || (ex_mag > ex_limit);
        ex_val   = ex_ovf ? ex_limit : ex_mag;
        if (term_neg)
            ex_val = 64'd0 - ex_val;
    end

    // ---------------------------------------------------------------- cosine index

    logic [51:0]        turns_full;
    logic [SCALE_W-1:0] scaled;
    logic [DEPTH_W:0]   idx_full;

    assign turns_full = big[51:0] - (item_reg.angle_now[31] ? pces_pkg::INV_2PI_WRAP : 52'd0);
    assign scaled     = SCALE_W'(turns_reg) * SCALE_W'(COS_TABLE_DEPTH)
                      + SCALE_W'(33'h0_8000_0000);
    assign idx_full   = scaled[SCALE_W-1:32];

    pces_cos_rom #(
        .COS_TABLE_DEPTH(COS_TABLE_DEPTH),
        .IDX_W(IDX_W)
    ) u_cos_rom (
        .clk(clk),
        .addr(idx_reg),
        .data(cos_q)
    );

    pces_prod_unit u_prod (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(prod_ctl),
        .stat(prod_stat),
        .big(big)
    );

    // ---------------------------------------------------------------- sequencer

    logic pot_on;
    logic ring_on;
    logic has_next;

    assign pot_on  = (mode_reg inside {pces_pkg::MODE_GRAV, pces_pkg::MODE_HARM});
    assign ring_on = item_reg.last_item && ring_reg;

    always_comb
    begin
        has_next  = 1'b0;
        term_next = pces_pkg::TERM_CPL_RING;
        case (term_reg)
            pces_pkg::TERM_KIN:
            begin
                has_next = pot_on || have_held_reg || ring_on;
                if (pot_on)
                    term_next = pces_pkg::TERM_POT;
                else if (have_held_reg)
                    term_next = pces_pkg::TERM_CPL_HELD;
            end
            pces_pkg::TERM_POT:
            begin
                has_next = have_held_reg || ring_on;
                if (have_held_reg)
                    term_next = pces_pkg::TERM_CPL_HELD;
            end
            pces_pkg::TERM_CPL_HELD:
            begin
                has_next = ring_on;
            end
            default:
            begin
                has_next = 1'b0;
            end
        endcase
    end

    assign in_accept = in_valid && !in_stall;
    assign emit_go   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        prod_ctl.load   = 1'b0;
        prod_ctl.start  = 1'b0;
        prod_ctl.factor = factor;
        case (state_reg)
            pces_pkg::ST_IDLE:
                if (in_valid)
                    state_next = pces_pkg::ST_TURN_LOAD;
            pces_pkg::ST_TURN_LOAD:
            begin
                prod_ctl.load   = 1'b1;
                prod_ctl.factor = {2'b0, item_reg.angle_now};
                state_next      = pces_pkg::ST_TURN_MUL;
            end
            pces_pkg::ST_TURN_MUL:
            begin
                prod_ctl.start  = 1'b1;
                prod_ctl.factor = pces_pkg::INV_2PI_Q32;
                state_next      = pces_pkg::ST_TURN_WAIT;
            end
            pces_pkg::ST_TURN_WAIT:
                if (prod_stat.done)
                    state_next = pces_pkg::ST_INDEX;
            pces_pkg::ST_INDEX:
                state_next = pces_pkg::ST_SCALE;
            pces_pkg::ST_SCALE:
                state_next = pces_pkg::ST_ROM;
            pces_pkg::ST_ROM:
                state_next = pces_pkg::ST_COS;
            pces_pkg::ST_COS:
                state_next = pces_pkg::ST_TERM_LOAD;
            pces_pkg::ST_TERM_LOAD:
            begin
                prod_ctl.load = 1'b1;
                state_next    = pces_pkg::ST_TERM_MUL;
            end
            pces_pkg::ST_TERM_MUL:
            begin
                prod_ctl.start = 1'b1;
                state_next     = pces_pkg::ST_TERM_WAIT;
            end
            pces_pkg::ST_TERM_WAIT:
                if (prod_stat.done)
                    state_next = (fidx_reg == fcount - 3'd1) ? pces_pkg::ST_EXTRACT
                                                             : pces_pkg::ST_TERM_MUL;
            pces_pkg::ST_EXTRACT:
                state_next = pces_pkg::ST_ADD;
            pces_pkg::ST_ADD:
                if (has_next)
                    state_next = pces_pkg::ST_TERM_LOAD;
                else if (item_reg.last_item)
                    state_next = pces_pkg::ST_TOTAL;
                else
                    state_next = pces_pkg::ST_IDLE;
            pces_pkg::ST_TOTAL:
                state_next = pces_pkg::ST_EMIT;
            pces_pkg::ST_EMIT:
                if (emit_go)
                    state_next = pces_pkg::ST_IDLE;
            default:
                state_next = pces_pkg::ST_IDLE;
        endcase
    end

    logic [64:0] acc_sum;
    logic [64:0] tot1;
    logic [64:0] tot2;

    always_comb
    begin
        case (term_reg)
            pces_pkg::TERM_KIN: acc_sum = sat_add(kin_acc_reg, term_val_reg);
            pces_pkg::TERM_POT: acc_sum = sat_add(pot_acc_reg, term_val_reg);
            default:            acc_sum = sat_add(cpl_acc_reg, term_val_reg);
        endcase
    end

    assign tot1 = sat_add(kin_acc_reg, cpl_acc_reg);
    assign tot2 = sat_add(t1_reg, pot_acc_reg);

    // ---------------------------------------------------------------- control registers

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pces_pkg::ST_IDLE;
            term_reg      <= pces_pkg::TERM_KIN;
            fidx_reg      <= '0;
            inv_dt_reg    <= 32'd256;
            mode_reg      <= pces_pkg::MODE_GRAV;
            ring_reg      <= 1'b1;
            kin_acc_reg   <= '0;
            cpl_acc_reg   <= '0;
            pot_acc_reg   <= '0;
            ovf_reg       <= 1'b0;
            have_held_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pces_pkg::CFG_INV_DT:   inv_dt_reg <= cfg_data;
                    pces_pkg::CFG_POT_MODE: mode_reg   <= cfg_data[1:0];
                    pces_pkg::CFG_RING:     ring_reg   <= cfg_data[0];
                    default:                ;
                endcase
            end
            if (state_reg == pces_pkg::ST_EMIT && emit_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                pces_pkg::ST_COS:
                    term_reg <= pces_pkg::TERM_KIN;
                pces_pkg::ST_TERM_LOAD:
                    fidx_reg <= 3'd1;
                pces_pkg::ST_TERM_WAIT:
                    if (prod_stat.done)
                        fidx_reg <= fidx_reg + 3'd1;
                pces_pkg::ST_EXTRACT:
                    fidx_reg <= '0;
                pces_pkg::ST_ADD:
                begin
                    ovf_reg  <= ovf_reg | term_ovf_reg | acc_sum[64];
                    term_reg <= term_next;
                    case (term_reg)
                        pces_pkg::TERM_KIN: kin_acc_reg <= acc_sum[63:0];
                        pces_pkg::TERM_POT: pot_acc_reg <= acc_sum[63:0];
                        default:            cpl_acc_reg <= acc_sum[63:0];
                    endcase
                    if (!has_next && !item_reg.last_item)
                        have_held_reg <= 1'b1;
                end
                pces_pkg::ST_TOTAL:
                    ovf_reg <= ovf_reg | tot1[64];
                pces_pkg::ST_EMIT:
                    if (emit_go)
                    begin
                        kin_acc_reg   <= '0;
                        cpl_acc_reg   <= '0;
                        pot_acc_reg   <= '0;
                        ovf_reg       <= 1'b0;
                        have_held_reg <= 1'b0;
                    end
                default:
                    ;
            endcase
        end
    end

    // ---------------------------------------------------------------- payload registers

    always_ff @(posedge clk)
    begin
        case (state_reg)
            pces_pkg::ST_IDLE:
                if (in_accept)
                begin
                    item_reg <= in_data;
                    if (!have_held_reg)
                        first_angle_reg <= in_data.angle_now;
                end
            pces_pkg::ST_INDEX:
                turns_reg <= turns_full[51:20];
            pces_pkg::ST_SCALE:
                idx_reg <= (idx_full >= (DEPTH_W+1)'(COS_TABLE_DEPTH)) ? '0
                                                                       : idx_full[IDX_W-1:0];
            pces_pkg::ST_COS:
                omc_reg <= 32'(pces_pkg::ONE_Q30 - {cos_q[31], cos_q});
            // the product register is complete only once the last limb has landed
            pces_pkg::ST_EXTRACT:
            begin
                term_val_reg <= ex_val;
                term_ovf_reg <= ex_ovf;
            end
            pces_pkg::ST_ADD:
                if (!has_next && !item_reg.last_item)
                begin
                    held_angle_reg    <= item_reg.angle_now;
                    held_mass_reg     <= item_reg.bob_mass;
                    held_length_reg   <= item_reg.arm_length;
                    held_coupling_reg <= item_reg.coupling_factor;
                    held_phase_reg    <= item_reg.phase_offset;
                end
            pces_pkg::ST_TOTAL:
                t1_reg <= tot1[63:0];
            pces_pkg::ST_EMIT:
                if (emit_go)
                begin
                    out_reg.kinetic_sum   <= kin_acc_reg;
                    out_reg.coupling_sum  <= cpl_acc_reg;
                    out_reg.potential_sum <= pot_acc_reg;
                    out_reg.total_sum     <= tot2[63:0];
                    out_reg.saturated     <= ovf_reg | tot2[64];
                end
            default:
                ;
        endcase
    end

    assign in_stall  = (state_reg != pces_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------------------------------------------------------- checks

    // a result only appears after the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == pces_pkg::ST_EMIT)
        else $error("result raised outside emit");

    // the multiplier only runs while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        prod_stat.busy |-> (state_reg == pces_pkg::ST_TURN_WAIT ||
                            state_reg == pces_pkg::ST_TERM_WAIT))
        else $error("multiplier busy outside a wait step");

    // sums and chain state are cleared once a result is emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pces_pkg::ST_EMIT && emit_go) |=>
            (kin_acc_reg == 64'sd0 && cpl_acc_reg == 64'sd0 && pot_acc_reg == 64'sd0 &&
             !have_held_reg && !ovf_reg))
        else $error("state not cleared after emit");

    // factor index stays inside the current term's factor list
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pces_pkg::ST_TERM_MUL |-> (fidx_reg != 3'd0 && fidx_reg < fcount))
        else $error("factor index out of range");

endmodule

[tb/tb_pendulum_chain_energy_sum_top.sv]
// tb_pendulum_chain_energy_sum_top: self-checking testbench for the pendulum chain energy block
// depends on pces_pkg and pendulum_chain_energy_sum_top; predicts every chain sum bit for bit
`timescale 1ns / 100ps

module tb_pendulum_chain_energy_sum_top;

    localparam int  COS_DEPTH   = 1024;
    localparam int  SETTLE      = 250;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic signed [64:0] I64_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] I64_MIN = -65'sh1_0000_0000_0000_0000 / 2;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    pces_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    pces_pkg::out_item_t out_data;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [31:0]         cfg_data;

    pendulum_chain_energy_sum_top #(.COS_TABLE_DEPTH(COS_DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic signed [31:0] cos_q30_tab [COS_DEPTH];
    logic [31:0] inv_dt_sq;
    logic [1:0]  pot_mode;
    logic        ring_on;
    longint      kin_sum, cpl_sum, pot_sum;
    longint      held_ang, held_cpl, held_ph, first_ang;
    logic [63:0] held_m, held_l;
    bit          have_prev, sat_seen;

    pces_pkg::out_item_t chain_sums_q[$];
    int          mismatches;
    int          items_sent;
    int          sums_checked;
    longint      cycles;
    bit          stall_calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] pr;
        pr = {64'b0, a} * {64'b0, b};
        return pr[125:62];
    endfunction

    task automatic build_cos_table();
        logic [63:0] u, z, z2, term, acc, c;
        bit          neg;
        for (int k = 0; k < COS_DEPTH; k++)
        begin
            u   = 4 * k;
            neg = 0;
            if (u > 2 * COS_DEPTH)
                u = 4 * COS_DEPTH - u;
            if (u > COS_DEPTH)
            begin
                u   = 2 * COS_DEPTH - u;
                neg = 1;
            end
            z    = (pces_pkg::HALF_PI_Q62 / COS_DEPTH) * u
                 + ((pces_pkg::HALF_PI_Q62 % COS_DEPTH) * u) / COS_DEPTH;
            z2   = q62_mul(z, z);
            term = 64'h4000_0000_0000_0000;
            acc  = term;
            for (int n = 1; n <= 11; n++)
            begin
                term = q62_mul(term, z2) / ((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            if (acc[63])
                acc = 0;
            c = (acc + 64'h8000_0000) >> 32;
            if (c > 64'h4000_0000)
                c = 64'h4000_0000;
            cos_q30_tab[k] = neg ? -$signed(c[31:0]) : $signed(c[31:0]);
        end
    endtask

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // exact product, truncated by the shift, clamped to the signed range
    function automatic longint energy_term(input logic [63:0] f [7], input int nf,
                                           input int sh, input bit neg);
        logic [255:0] p;
        logic [63:0]  mag, lim;
        p = 256'd1;
        for (int i = 0; i < nf; i++)
            p = p * {192'b0, f[i]};
        p   = p >> sh;
        mag = p[63:0];
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (p[255:64] != 0 || mag > lim)
        begin
            mag      = lim;
            sat_seen = 1;
        end
        return neg ? longint'(-mag) : longint'(mag);
    endfunction

    function automatic longint add_clamped(input longint a, input longint b);
        logic signed [64:0] s;
        s = a;
        s = s + b;
        if (s > I64_MAX)
        begin
            sat_seen = 1;
            return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        if (s < I64_MIN)
        begin
            sat_seen = 1;
            return 64'h8000_0000_0000_0000;
        end
        return longint'(s[63:0]);
    endfunction

    function automatic longint coupling_energy(input longint x, input longint nxt,
                                               input longint ph, input logic [63:0] m,
                                               input logic [63:0] l, input longint kap);
        logic [63:0] dm;
        dm = magnitude(x - (nxt - ph));
        return energy_term('{dm, dm, l, l, m, magnitude(kap), {32'b0, inv_dt_sq}}, 7,
                           pces_pkg::SHIFT_CPL, kap > 0);
    endfunction

    function automatic void clear_chain();
        kin_sum   = 0;
        cpl_sum   = 0;
        pot_sum   = 0;
        held_ang  = 0;
        held_cpl  = 0;
        held_ph   = 0;
        first_ang = 0;
        held_m    = 0;
        held_l    = 0;
        have_prev = 0;
        sat_seen  = 0;
    endfunction

    task automatic predict_pendulum(input pces_pkg::in_item_t it);
        longint      now_a, gam, kap, ph;
        logic [63:0] m, l, v, pr, idx, omc;
        logic [31:0] turns;
        pces_pkg::out_item_t res;
        now_a = it.angle_now;
        gam   = it.gravity_factor;
        kap   = it.coupling_factor;
        ph    = it.phase_offset;
        m     = {40'b0, it.bob_mass};
        l     = {40'b0, it.arm_length};
        v     = magnitude(now_a - longint'(it.angle_before));
        kin_sum = add_clamped(kin_sum, energy_term('{v, v, m, l, l, {32'b0, inv_dt_sq}, 64'd0},
                                                   6, pces_pkg::SHIFT_KIN, 0));
        if (pot_mode == pces_pkg::MODE_GRAV)
        begin
            pr    = 64'(now_a) * 64'd683565276;
            turns = pr[51:20];
            idx   = ({32'b0, turns} * COS_DEPTH + 64'h8000_0000) >> 32;
            if (idx >= COS_DEPTH)
                idx = 0;
            omc = 64'(longint'(1 << 30) - longint'(cos_q30_tab[idx]));
            pot_sum = add_clamped(pot_sum,
                energy_term('{m, magnitude(gam), l, omc, {32'b0, inv_dt_sq}, 64'd0, 64'd0},
                            5, pces_pkg::SHIFT_GRAV, gam > 0));
        end
        else if (pot_mode == pces_pkg::MODE_HARM)
        begin
            v = magnitude(now_a);
            pot_sum = add_clamped(pot_sum,
                energy_term('{m, magnitude(gam), l, v, v, {32'b0, inv_dt_sq}, 64'd0},
                            6, pces_pkg::SHIFT_HARM, gam > 0));
        end
        if (have_prev)
            cpl_sum = add_clamped(cpl_sum,
                coupling_energy(held_ang, now_a, held_ph, held_m, held_l, held_cpl));
        else
            first_ang = now_a;
        if (!it.last_item)
        begin
            held_ang  = now_a;
            held_m    = m;
            held_l    = l;
            held_cpl  = kap;
            held_ph   = ph;
            have_prev = 1;
        end
        else
        begin
            if (ring_on)
                cpl_sum = add_clamped(cpl_sum, coupling_energy(now_a, first_ang, ph, m, l, kap));
            res.kinetic_sum   = kin_sum;
            res.coupling_sum  = cpl_sum;
            res.potential_sum = pot_sum;
            res.total_sum     = add_clamped(add_clamped(kin_sum, cpl_sum), pot_sum);
            res.saturated     = sat_seen;
            chain_sums_q.push_back(res);
            clear_chain();
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called and returns at a falling edge
    task automatic send_pendulum(input pces_pkg::in_item_t it);
        int gap;
        in_data  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_pendulum(it);
        items_sent++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        while (chain_sums_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        in_valid <= 1'b0;
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == pces_pkg::CFG_INV_DT)
            inv_dt_sq = val;
        else if (idx == pces_pkg::CFG_POT_MODE)
            pot_mode = val[1:0];
        else if (idx == pces_pkg::CFG_RING)
            ring_on = val[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
        if (r < 8)
            return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        return $urandom;
    endfunction

    function automatic logic [23:0] rand_q816();
        if ($urandom_range(0, 9) < 8)
            return 24'($urandom_range(0, 1 << 18));
        return 24'($urandom);
    endfunction

    function automatic logic [31:0] rand_q130();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return -32'($urandom_range(0, 1 << 30));
        if (r < 8)
            return 32'($urandom_range(0, 1 << 30));
        return $urandom;
    endfunction

    function automatic pces_pkg::in_item_t rand_pendulum(input bit last);
        pces_pkg::in_item_t it;
        it.angle_now       = rand_angle();
        it.angle_before    = ($urandom_range(0, 3) == 0) ? rand_angle()
                             : it.angle_now + 32'($signed($urandom_range(0, 4095)) - 2048);
        it.bob_mass        = rand_q816();
        it.arm_length      = rand_q816();
        it.gravity_factor  = rand_q130();
        it.coupling_factor = rand_q130();
        it.phase_offset    = ($urandom_range(0, 2) == 0) ? rand_angle() : 32'd0;
        it.last_item       = last;
        return it;
    endfunction

    function automatic pces_pkg::in_item_t make_pendulum(input logic [31:0] a,
                                               input logic [31:0] b,
                                               input logic [23:0] m, input logic [23:0] l,
                                               input logic [31:0] g, input logic [31:0] k,
                                               input logic [31:0] ph, input bit last);
        pces_pkg::in_item_t it;
        it.angle_now       = a;
        it.angle_before    = b;
        it.bob_mass        = m;
        it.arm_length      = l;
        it.gravity_factor  = g;
        it.coupling_factor = k;
        it.phase_offset    = ph;
        it.last_item       = last;
        return it;
    endfunction

    task automatic send_chain(input int len);
        for (int i = 0; i < len; i++)
            send_pendulum(rand_pendulum(i == len - 1));
    endtask

    // reset settings, field extremes, single pendulum ring, saturation
    task automatic test_directed_extremes();
        send_pendulum(make_pendulum(0, 0, 0, 0, 0, 0, 0, 1));
        send_pendulum(make_pendulum(32'h0010_0000, 0, 24'h01_0000, 24'h01_0000,
                                    32'hF000_0000, 32'hF000_0000, 0, 1));
        send_pendulum(make_pendulum(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 24'hFF_FFFF,
                                    32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        send_pendulum(make_pendulum(32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1));
        send_pendulum(make_pendulum(32'h0032_4000, 32'hFFCD_C000, 24'h02_0000, 24'h00_8000,
                                    32'hC000_0000, 32'h4000_0000, 32'h0001_0000, 0));
        send_pendulum(make_pendulum(32'hFFF0_0000, 32'h0000_0001, 24'h00_0001, 24'h00_0001,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        send_pendulum(make_pendulum(32'h0064_8000, 32'h0064_8000, 24'h01_0000, 24'h01_0000,
                                    32'hE000_0000, 32'hE000_0000, 0, 1));
        // saturated chain followed by a clean one shows the flag clears
        for (int i = 0; i < 4; i++)
            send_pendulum(make_pendulum(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 24'hFF_FFFF,
                                        32'h8000_0000, 32'h7FFF_FFFF, 0, i == 3));
        send_pendulum(make_pendulum(32'h0000_1000, 0, 24'h01_0000, 24'h01_0000,
                                    32'hF000_0000, 32'hF000_0000, 0, 1));
    endtask

    // every potential mode including the unused encoding, with open and closed ring
    task automatic test_potential_modes();
        for (int md = 0; md < 4; md++)
        begin
            write_reg(pces_pkg::CFG_POT_MODE, md);
            write_reg(pces_pkg::CFG_RING, md % 2);
            send_pendulum(make_pendulum(32'h0032_4000, 32'h0030_0000, 24'h01_8000,
                                        24'h02_0000, 32'hF800_0000, 32'hF000_0000,
                                        32'h0008_0000, 0));
            send_pendulum(make_pendulum(32'hFFC0_0000, 32'hFFC1_0000, 24'h00_8000,
                                        24'h01_0000, 32'h0800_0000, 32'hF000_0000, 0, 1));
            send_pendulum(make_pendulum(32'h1234_5678, 32'h0000_0000, 24'h01_0000,
                                        24'h01_0000, 32'hC000_0000, 32'h4000_0000, 0, 1));
        end
    endtask

    task automatic test_random_chains(input logic [31:0] dt, input logic [1:0] md,
                                      input bit ring, input int n_items);
        int done_items;
        int len;
        write_reg(pces_pkg::CFG_INV_DT, dt);
        write_reg(pces_pkg::CFG_POT_MODE, md);
        write_reg(pces_pkg::CFG_RING, ring);
        done_items = 0;
        while (done_items < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
            send_chain(len);
            done_items += len;
        end
    endtask

    // result side: stalls of random length with calm stretches
    initial
    begin
        out_stall  = 1'b0;
        stall_calm = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                stall_calm = ~stall_calm;
            if (stall_calm || $urandom_range(0, 1) == 0)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 3))
                    @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        pces_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (chain_sums_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", out_data);
            end
            else
            begin
                want = chain_sums_q.pop_front();
                sums_checked++;
                if (out_data.kinetic_sum !== want.kinetic_sum
                    || out_data.coupling_sum !== want.coupling_sum
                    || out_data.potential_sum !== want.potential_sum
                    || out_data.total_sum !== want.total_sum
                    || out_data.saturated !== want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("chain %0d mismatch: kin %h/%h cpl %h/%h pot %h/%h",
                                 sums_checked, want.kinetic_sum, out_data.kinetic_sum,
                                 want.coupling_sum, out_data.coupling_sum,
                                 want.potential_sum, out_data.potential_sum);
                        $display("  total %h/%h sat %b/%b (expected/actual)",
                                 want.total_sum, out_data.total_sum,
                                 want.saturated, out_data.saturated);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = pces_pkg::CFG_INV_DT;
        cfg_data   = '0;
        mismatches = 0;
        items_sent = 0;
        sums_checked = 0;
        cycles     = 0;
        inv_dt_sq  = 32'd256;
        pot_mode   = pces_pkg::MODE_GRAV;
        ring_on    = 1'b1;
        build_cos_table();
        clear_chain();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_extremes();
        test_potential_modes();
        test_random_chains(32'd256, pces_pkg::MODE_GRAV, 1, 110);
        test_random_chains(32'd0, pces_pkg::MODE_HARM, 0, 60);
        test_random_chains(32'hFFFF_FFFF, pces_pkg::MODE_GRAV, 1, 60);
        test_random_chains(32'd1, pces_pkg::MODE_HARM, 1, 90);
        test_random_chains($urandom_range(64, 4096), pces_pkg::MODE_NONE, 1, 90);
        test_random_chains($urandom, pces_pkg::MODE_SPARE, 0, 60);
        test_random_chains(32'd1024, pces_pkg::MODE_GRAV, 0, 110);
        test_random_chains($urandom_range(1, 1024), pces_pkg::MODE_HARM, 1, 110);

        in_valid <= 1'b0;
        while (chain_sums_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("sent %0d pendulums, checked %0d chain sums", items_sent, sums_checked);
        $display("covered all potential modes, open and closed ring, time step extremes");
        if (mismatches == 0 && chain_sums_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[pendulum_chain_energy_sum_top.f]
rtl/pces_pkg.sv
rtl/pces_cos_rom.sv
rtl/pces_prod_unit.sv
rtl/pendulum_chain_energy_sum_top.sv
tb/tb_pendulum_chain_energy_sum_top.sv
